/* hdl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/eihd_pkg.sv */
package eihd_pkg;

  // default build limits
  localparam int DEF_MAX_LEN = 32;
  localparam int DEF_MAX_GAP = 16;

  // fixed field widths
  localparam int SEQ_W   = 64;
  localparam int LANES   = 32;
  localparam int CNT_W   = 6;
  localparam int GAP_W   = 5;
  localparam int CFG_W   = 6;
  localparam int INDEX_W = 2;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_CONTEXT_LENGTH = 2'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_GAP        = 2'd1;
  localparam logic [INDEX_W-1:0] REG_MAX_MISMATCHES = 2'd2;

  // register reset values
  localparam logic [5:0] RST_CONTEXT_LENGTH = 6'd31;
  localparam logic [4:0] RST_MAX_GAP        = 5'd10;
  localparam logic [5:0] RST_MAX_MISMATCHES = 6'd3;

  // cost of an alignment that is not tried, above any real cost
  localparam logic [CNT_W-1:0] COST_NONE = '1;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] gmax;
  } limits_t;

  typedef struct packed {
    logic [CNT_W-1:0] cost;
    logic [GAP_W-1:0] gap;
  } cand_t;

  // five-level adder tree over 32 bits
  function automatic logic [CNT_W-1:0] popcount32(input logic [LANES-1:0] v);
    logic [LANES-1:0] s;
    s = (v & 32'h5555_5555) + ((v >> 1) & 32'h5555_5555);
    s = (s & 32'h3333_3333) + ((s >> 2) & 32'h3333_3333);
    s = (s & 32'h0F0F_0F0F) + ((s >> 4) & 32'h0F0F_0F0F);
    s = (s & 32'h00FF_00FF) + ((s >> 8) & 32'h00FF_00FF);
    s = (s & 32'h0000_FFFF) + ((s >> 16) & 32'h0000_FFFF);
    return s[CNT_W-1:0];
  endfunction

endpackage

/* hdl/eihd_align_cost.sv */
module eihd_align_cost #(
  parameter int MAX_LEN = eihd_pkg::DEF_MAX_LEN,
  parameter int MAX_GAP = eihd_pkg::DEF_MAX_GAP
) (
  input  logic [eihd_pkg::SEQ_W-1:0] seq_a,
  input  logic [eihd_pkg::SEQ_W-1:0] seq_b,
  input  eihd_pkg::limits_t          lim,
  output logic [eihd_pkg::CNT_W-1:0] plain,
  output eihd_pkg::cand_t            cand_a [MAX_GAP],
  output eihd_pkg::cand_t            cand_b [MAX_GAP]
);
  import eihd_pkg::*;

  // per-base mismatch flags, one vector per alignment
  logic [LANES-1:0] da [MAX_GAP+1];
  logic [LANES-1:0] db [1:MAX_GAP];

  // seq_a shifted right by g bases against full seq_b (g = 0 is plain)
  for (genvar g = 0; g <= MAX_GAP; g++) begin : g_shift_a
    for (genvar i = 0; i < LANES; i++) begin : g_lane
      if (i + g < MAX_LEN) begin : g_on
        assign da[g][i] = (seq_a[2*(i+g) +: 2] != seq_b[2*i +: 2]) &&
                          (CNT_W'(i + g) < lim.len);
      end else begin : g_off
        assign da[g][i] = 1'b0;
      end
    end
  end

  // seq_b shifted right by g bases against full seq_a
  for (genvar g = 1; g <= MAX_GAP; g++) begin : g_shift_b
    for (genvar i = 0; i < LANES; i++) begin : g_lane
      if (i + g < MAX_LEN) begin : g_on
        assign db[g][i] = (seq_a[2*i +: 2] != seq_b[2*(i+g) +: 2]) &&
                          (CNT_W'(i + g) < lim.len);
      end else begin : g_off
        assign db[g][i] = 1'b0;
      end
    end
  end

  assign plain = popcount32(da[0]);

  // gap cost added, gaps beyond the bound get a cost nothing can lose to
  for (genvar g = 1; g <= MAX_GAP; g++) begin : g_cost
    assign cand_a[g-1].gap  = GAP_W'(g);
    assign cand_b[g-1].gap  = GAP_W'(g);
    assign cand_a[g-1].cost = (CNT_W'(g) <= lim.gmax) ?
                              popcount32(da[g]) + CNT_W'(g) : COST_NONE;
    assign cand_b[g-1].cost = (CNT_W'(g) <= lim.gmax) ?
                              popcount32(db[g]) + CNT_W'(g) : COST_NONE;
  end

endmodule

/* hdl/eihd_min_tree.sv */
module eihd_min_tree #(
  parameter int N = eihd_pkg::DEF_MAX_GAP
) (
  input  eihd_pkg::cand_t leaf [N],
  output eihd_pkg::cand_t best
);
  import eihd_pkg::*;

  localparam int DEPTH = $clog2(N);
  localparam int P     = 1 << DEPTH;

  cand_t pad  [P];
  cand_t node [1:2*P-1];

  // pad to a power of two on the right, so padding never wins a tie
  for (genvar j = 0; j < P; j++) begin : g_pad
    if (j < N) begin : g_real
      assign pad[j] = leaf[j];
    end else begin : g_fill
      assign pad[j] = '{cost: COST_NONE, gap: '0};
    end
  end

  // heap-ordered tree, left (smaller gap) wins on equal cost
  always_comb begin
    for (int j = 0; j < P; j++) begin
      node[P+j] = pad[j];
    end
    for (int i = P - 1; i >= 1; i--) begin
      node[i] = (node[2*i].cost <= node[2*i+1].cost) ? node[2*i] : node[2*i+1];
    end
  end

  assign best = node[1];

endmodule

/* hdl/end_indel_hamming_distance.sv */
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   seq_a, seq_b
// out       output     out_valid / out_stall mismatches, indel_length, accepted
// cfg       input      cfg_we                cfg_index, cfg_data
//
// one pair per cycle sustained while out_stall stays low; a result passes through the
// input register, count register, minimum register and result register
// rst is synchronous and clears the stage valid bits and the configuration registers to their defaults
// a stalled result holds; earlier stages keep filling until every stage is occupied,
// and only then in_stall rises
module end_indel_hamming_distance #(
  parameter int MAX_LEN = eihd_pkg::DEF_MAX_LEN,
  parameter int MAX_GAP = eihd_pkg::DEF_MAX_GAP
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [eihd_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [eihd_pkg::CFG_W-1:0]    cfg_data,
  // request in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [eihd_pkg::SEQ_W-1:0]    seq_a,
  input  logic [eihd_pkg::SEQ_W-1:0]    seq_b,
  // request out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [eihd_pkg::CNT_W-1:0]    mismatches,
  output logic signed [eihd_pkg::CNT_W-1:0] indel_length,
  output logic                          accepted
);
  import eihd_pkg::*;

  // configuration registers
  logic [5:0] context_length;
  logic [4:0] max_gap;
  logic [5:0] max_mismatches;

  always_ff @(posedge clk) begin
    if (rst) begin
      context_length <= RST_CONTEXT_LENGTH;
      max_gap        <= RST_MAX_GAP;
      max_mismatches <= RST_MAX_MISMATCHES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONTEXT_LENGTH: context_length <= cfg_data[5:0];
        REG_MAX_GAP:        max_gap        <= cfg_data[4:0];
        REG_MAX_MISMATCHES: max_mismatches <= cfg_data[5:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // effective length and gap bound; the user must move config only while idle, the block does not enforce it
  limits_t          lim;
  logic [CNT_W-1:0] gap_cap;

  always_comb begin
    lim.len = (context_length > CNT_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : context_length;
    gap_cap = ({1'b0, max_gap} > CNT_W'(MAX_GAP)) ? CNT_W'(MAX_GAP) : {1'b0, max_gap};
    lim.gmax = (gap_cap > lim.len) ? lim.len : gap_cap;
  end

  // stage valids and the ready chain, each stage fills its own bubble
  logic v0, v1, v2;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  // stage 0: input pair
  logic [SEQ_W-1:0] a_q, b_q;

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      a_q <= seq_a;
      b_q <= seq_b;
    end
  end

  // stage 1: mismatch counts of every alignment
  logic [CNT_W-1:0] plain_c;
  cand_t            cand_a_c [MAX_GAP];
  cand_t            cand_b_c [MAX_GAP];
  logic [CNT_W-1:0] plain_q;
  cand_t            cand_a_q [MAX_GAP];
  cand_t            cand_b_q [MAX_GAP];

  eihd_align_cost #(
    .MAX_LEN (MAX_LEN),
    .MAX_GAP (MAX_GAP)
  ) u_cost (
    .seq_a  (a_q),
    .seq_b  (b_q),
    .lim    (lim),
    .plain  (plain_c),
    .cand_a (cand_a_c),
    .cand_b (cand_b_c)
  );

  always_ff @(posedge clk) begin
    if (v0 && rdy1) begin
      plain_q  <= plain_c;
      cand_a_q <= cand_a_c;
      cand_b_q <= cand_b_c;
    end
  end

  // stage 2: first minimum on each side
  cand_t            best_a_c, best_b_c;
  cand_t            best_a_q, best_b_q;
  logic [CNT_W-1:0] plain2_q;

  eihd_min_tree #(.N (MAX_GAP)) u_min_a (
    .leaf (cand_a_q),
    .best (best_a_c)
  );

  eihd_min_tree #(.N (MAX_GAP)) u_min_b (
    .leaf (cand_b_q),
    .best (best_b_c)
  );

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      plain2_q <= plain_q;
      best_a_q <= best_a_c;
      best_b_q <= best_b_c;
    end
  end

  // stage 3: pick the alignment; no indel needs a strict win over both sides,
  // a tie between the sides goes to insertion in seq_b
  logic [CNT_W-1:0]        mis_c;
  logic signed [CNT_W-1:0] indel_c;

  always_comb begin
    if ((lim.gmax == '0) || ((plain2_q < best_a_q.cost) && (plain2_q < best_b_q.cost))) begin
      mis_c   = plain2_q;
      indel_c = '0;
    end else if (best_a_q.cost < best_b_q.cost) begin
      mis_c   = best_a_q.cost - CNT_W'(best_a_q.gap);
      indel_c = $signed(CNT_W'(best_a_q.gap));
    end else begin
      mis_c   = best_b_q.cost - CNT_W'(best_b_q.gap);
      indel_c = -$signed(CNT_W'(best_b_q.gap));
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      mismatches   <= mis_c;
      indel_length <= indel_c;
      accepted     <= (mis_c <= max_mismatches);
    end
  end

endmodule

/* hdl/eihd_checker.sv */
`include "assert_macros.svh"

module eihd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [eihd_pkg::CNT_W-1:0]        mismatches,
  input logic signed [eihd_pkg::CNT_W-1:0] indel_length,
  input logic                              accepted
);

  // pipeline comes out of reset empty and open
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_stall, "pipeline not empty after reset")

  // input can only back up behind a stalled result
  `ASSERT_CLK(a_stall_source, in_stall |-> out_valid && out_stall, "input stalled without a stalled result")

  // a request reaches the output when the result side does not stall while it passes through
  `ASSERT_CLK(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "result missing after pipeline latency")

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(mismatches) && $stable(indel_length) && $stable(accepted), "stalled result changed")

endmodule

bind end_indel_hamming_distance eihd_checker u_eihd_checker (.*);

/* tb/end_indel_hamming_distance_test.sv */
`timescale 1ns / 100ps

module end_indel_hamming_distance_test;
  import eihd_pkg::*;

  localparam int MAX_LEN = DEF_MAX_LEN;
  localparam int MAX_GAP = DEF_MAX_GAP;

  // the index port has one code that maps to no register
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_PAIRS = 900;
  localparam int PHASE_PAIRS  = 60;
  localparam int BURST_PAIRS  = 20;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 12;

  localparam logic [SEQ_W-1:0] ONES = '1;
  localparam logic [SEQ_W-1:0] MIX  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [SEQ_W-1:0] TOP_BASE = 64'hC000_0000_0000_0000;

  // one alignment verdict, laid out like the result ports
  typedef struct packed {
    logic [CNT_W-1:0]        mis;
    logic signed [CNT_W-1:0] indel;
    logic                    ok;
  } score_t;

  typedef enum {STEP_WRITE, STEP_PAIR, STEP_TYPED} step_kind_t;

  // one row of the directed plan: a register write or a pair of contexts
  typedef struct {
    step_kind_t         kind;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;
    logic [SEQ_W-1:0]   a;
    logic [SEQ_W-1:0]   b;
    score_t             want;
  } step_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [INDEX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SEQ_W-1:0]        seq_a = '0;
  logic [SEQ_W-1:0]        seq_b = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CNT_W-1:0]        mismatches;
  logic signed [CNT_W-1:0] indel_length;
  logic                    accepted;

  // local copy of the three registers
  logic [CFG_W-1:0] ctx_len = RST_CONTEXT_LENGTH;
  logic [GAP_W-1:0] gap_lim = RST_MAX_GAP;
  logic [CFG_W-1:0] mis_lim = RST_MAX_MISMATCHES;

  score_t pending_scores[$];
  step_t  directed_plan[$];

  // idle knobs for the two sides, flipped now and then to get bursts
  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;

  int errors        = 0;
  int pairs_sent    = 0;
  int reg_writes    = 0;
  int results_seen  = 0;
  int indel_results = 0;
  int pass_results  = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  end_indel_hamming_distance DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .seq_a        (seq_a),
    .seq_b        (seq_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mismatches   (mismatches),
    .indel_length (indel_length),
    .accepted     (accepted)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mismatching bases among the n lowest bases of x and y
  function automatic int base_diffs(logic [SEQ_W-1:0] x, logic [SEQ_W-1:0] y, int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++)
      if (x[2*i +: 2] != y[2*i +: 2]) c++;
    return c;
  endfunction

  // best right-end alignment of a against b under the current registers
  function automatic score_t score_pair(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    int     len, gmax, plain, best_a, best_b, gap_a, gap_b, ca, cb;
    score_t s;
    // length saturates at the build limit, gap bound at both limits
    len  = (ctx_len > MAX_LEN) ? MAX_LEN : int'(ctx_len);
    gmax = (gap_lim > MAX_GAP) ? MAX_GAP : int'(gap_lim);
    if (gmax > len) gmax = len;
    plain  = base_diffs(a, b, len);
    best_a = 0;
    best_b = 0;
    gap_a  = 0;
    gap_b  = 0;
    // a gap as long as the context leaves an empty side costing the gap alone
    for (int g = 1; g <= gmax; g++) begin
      ca = base_diffs(a >> (2 * g), b, len - g) + g;
      cb = base_diffs(a, b >> (2 * g), len - g) + g;
      // first minimum wins on each side
      if (g == 1 || ca < best_a) begin
        best_a = ca;
        gap_a  = g;
      end
      if (g == 1 || cb < best_b) begin
        best_b = cb;
        gap_b  = g;
      end
    end
    // no indel only when strictly cheaper; side tie goes to insertion in b
    if (gmax == 0 || (plain < best_a && plain < best_b)) begin
      s.mis   = CNT_W'(plain);
      s.indel = '0;
    end else if (best_a < best_b) begin
      s.mis   = CNT_W'(best_a - gap_a);
      s.indel = CNT_W'(gap_a);
    end else begin
      s.mis   = CNT_W'(best_b - gap_b);
      s.indel = CNT_W'(-gap_b);
    end
    s.ok = (s.mis <= mis_lim);
    return s;
  endfunction

  function automatic void add_write(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
    step_t st;
    st = '{STEP_WRITE, index, data, '0, '0, '0};
    directed_plan = {directed_plan, st};
  endfunction

  function automatic void add_pair(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    step_t st;
    st = '{STEP_PAIR, '0, '0, a, b, '0};
    directed_plan = {directed_plan, st};
  endfunction

  function automatic void add_typed(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b, score_t want);
    step_t st;
    st = '{STEP_TYPED, '0, '0, a, b, want};
    directed_plan = {directed_plan, st};
  endfunction

  // offer one pair, after a random gap while in_idle is set; returns at the edge that takes it,
  // with in_valid still high so a back-to-back request keeps it there
  task automatic send_pair(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b, bit typed,
                           score_t want);
    int     wait_cycles;
    score_t s;
    wait_cycles = in_idle ? $urandom_range(0, 4) : 0;
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_a    <= a;
    seq_b    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s = typed ? want : score_pair(a, b);
    pending_scores = {pending_scores, s};
    pairs_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_CONTEXT_LENGTH: ctx_len = data;
      REG_MAX_GAP:        gap_lim = data[GAP_W-1:0];
      REG_MAX_MISMATCHES: mis_lim = data;
      default: ;  // unused index leaves every register alone
    endcase
    reg_writes++;
    // enable goes low between writes
    @(posedge clk);
  endtask

  // result side: random stall after each taken result, field-by-field check
  always @(posedge clk) begin
    score_t got, want;
    int     n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      got = '{mismatches, indel_length, accepted};
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result mismatches %0d indel %0d accepted %0b",
                 $time, got.mis, $signed(got.indel), got.ok);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (got.mis !== want.mis) begin
          $display("%0t: mismatches expected %0d got %0d", $time, want.mis, got.mis);
          errors++;
        end
        if (got.indel !== want.indel) begin
          $display("%0t: indel_length expected %0d got %0d", $time,
                   $signed(want.indel), $signed(got.indel));
          errors++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t: accepted expected %0b got %0b", $time, want.ok, got.ok);
          errors++;
        end
      end
      results_seen++;
      if (got.indel != 0) indel_results++;
      if (got.ok) pass_results++;
      n = out_idle ? $urandom_range(0, 4) : 0;
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // cycles in a row with no request moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: watchdog, no request moved for %0d cycles", $time, QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [SEQ_W-1:0] a, b, low_mask;
    int               gap, nflip, shape, directed_pairs;
    step_t            st;

    // reset registers: length 31, gap 10, limit 3
    add_typed('0, '0, '{6'd0, 6'sd0, 1'b1});
    add_typed(ONES, ONES, '{6'd0, 6'sd0, 1'b1});
    // only the base above the context differs
    add_typed('0, TOP_BASE, '{6'd0, 6'sd0, 1'b1});
    // every shift costs the same, tie between sides
    add_pair('0, {32{2'b01}});
    // one extra base on the right of a, then of b
    add_pair({MIX[61:0], 2'b10}, MIX);
    add_pair(MIX, {MIX[61:0], 2'b01});
    add_pair(MIX, MIX ^ 64'h3);
    // full length now reaches the top base
    add_write(REG_CONTEXT_LENGTH, 6'd32);
    add_pair('0, TOP_BASE);
    add_pair(ONES, '0);
    // empty contexts
    add_write(REG_CONTEXT_LENGTH, 6'd0);
    add_typed(MIX, ~MIX, '{6'd0, 6'sd0, 1'b1});
    // length above the limit saturates, indels off, loosest and tightest limit
    add_write(REG_CONTEXT_LENGTH, 6'd63);
    add_write(REG_MAX_GAP, 6'd0);
    add_write(REG_MAX_MISMATCHES, 6'd32);
    add_typed('0, ONES, '{6'd32, 6'sd0, 1'b1});
    add_write(REG_MAX_MISMATCHES, 6'd0);
    add_typed('0, ONES, '{6'd32, 6'sd0, 1'b0});
    add_typed(MIX, MIX, '{6'd0, 6'sd0, 1'b1});
    // gap bound above the build limit, longest indel either way
    add_write(REG_MAX_GAP, 6'd31);
    add_write(REG_MAX_MISMATCHES, 6'd63);
    add_pair({MIX[31:0], ~MIX[63:32]}, MIX);
    add_pair(MIX, {MIX[31:0], ~MIX[63:32]});
    // single base: a gap empties one side
    add_write(REG_CONTEXT_LENGTH, 6'd1);
    add_pair('0, 64'h1);
    // gap bound cut down to a short length
    add_write(REG_CONTEXT_LENGTH, 6'd4);
    add_write(REG_MAX_GAP, 6'd16);
    add_pair(MIX, ~MIX);
    add_pair(64'h1B, 64'h6C);
    // write to the unused index must not disturb anything
    add_write(REG_SPARE, 6'd5);
    add_pair(MIX, {MIX[61:0], 2'b11});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      st = directed_plan[i];
      if (st.kind == STEP_WRITE) begin
        write_reg(st.index, st.data);
      end else begin
        send_pair(st.a, st.b, st.kind == STEP_TYPED, st.want);
      end
    end
    directed_pairs = pairs_sent;

    // random phases, each under fresh register values
    for (int phase = 0; phase < RANDOM_PAIRS / PHASE_PAIRS; phase++) begin
      // mostly legal values, now and then the whole port range
      write_reg(REG_CONTEXT_LENGTH, CFG_W'(($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 63) : $urandom_range(1, MAX_LEN)));
      write_reg(REG_MAX_GAP, CFG_W'(($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 63) : $urandom_range(0, MAX_GAP)));
      write_reg(REG_MAX_MISMATCHES, CFG_W'(($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 63) : $urandom_range(0, 8)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 63)));

      for (int k = 0; k < PHASE_PAIRS; k++) begin
        // stretches with and without idling on each side
        if (k % BURST_PAIRS == 0) begin
          in_idle  = ($urandom_range(0, 3) != 0);
          out_idle = ($urandom_range(0, 3) != 0);
        end
        b        = {$urandom, $urandom};
        gap      = $urandom_range(1, MAX_GAP);
        low_mask = (64'd1 << (2 * gap)) - 64'd1;
        shape    = $urandom_range(0, 9);
        case (shape)
          0, 1: a = b;
          // extra bases at the right end of a
          2, 3, 4: a = (b << (2 * gap)) | ({$urandom, $urandom} & low_mask);
          // extra bases at the right end of b
          5, 6, 7: begin
            a = b;
            b = (a << (2 * gap)) | ({$urandom, $urandom} & low_mask);
          end
          default: a = {$urandom, $urandom};
        endcase
        // a few point changes on top of the shaped pairs
        if (shape < 8) begin
          nflip = $urandom_range(0, 3);
          for (int m = 0; m < nflip; m++)
            a ^= 64'($urandom_range(1, 3)) << (2 * $urandom_range(0, 31));
        end
        send_pair(a, b, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d pairs (%0d directed, rest random) over %0d register writes",
             pairs_sent, directed_pairs, reg_writes);
    $display("run: %0d results checked, %0d with an end indel, %0d passing the limit",
             results_seen, indel_results, pass_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
